// File: design/rbkwq_pkg.sv
// Package for the read base k-window qualifier: configuration, queue entry and
// result types, and the codes shared by the front end, queue, back end and top level.
// No dependencies.
package rbkwq_pkg;

	// Register indexes of the configuration port.
	localparam logic [2:0] CFG_WINDOW_LEN        = 3'd0;
	localparam logic [2:0] CFG_MIN_QUALITY       = 3'd1;
	localparam logic [2:0] CFG_RNA_MODE          = 3'd2;
	localparam logic [2:0] CFG_REJECT_AMBIGUOUS  = 3'd3;
	localparam logic [2:0] CFG_HOMOPOLYMER_MERGE = 3'd4;

	// Base codes.
	localparam logic [2:0] BASE_A = 3'd0;
	localparam logic [2:0] BASE_C = 3'd1;
	localparam logic [2:0] BASE_G = 3'd2;
	localparam logic [2:0] BASE_T = 3'd3;
	localparam logic [2:0] BASE_N = 3'd4;

	// Record error codes.
	localparam logic [1:0] ERR_NONE         = 2'd0;
	localparam logic [1:0] ERR_AMBIGUOUS    = 2'd1;
	localparam logic [1:0] ERR_QUAL_RANGE   = 2'd2;
	localparam logic [1:0] ERR_QUAL_MISSING = 2'd3;

	// Window classes.
	localparam logic [1:0] CLS_NONE      = 2'd0;
	localparam logic [1:0] CLS_ACCEPTED  = 2'd1;
	localparam logic [1:0] CLS_AMBIGUOUS = 2'd2;
	localparam logic [1:0] CLS_LOW       = 2'd3;

	// Phred+33 printable range.
	localparam logic [7:0] PHRED_OFFSET = 8'd33;
	localparam logic [7:0] PHRED_TOP    = 8'd126;

	// Saturation value of the record counters.
	localparam logic [6:0] CNT_MAX = 7'd127;

	// Entries of the command queue between front and back.
	localparam int QUEUE_DEPTH = 4;

	// Reset values of the configuration registers.
	localparam logic [6:0] WINDOW_LEN_RESET  = 7'd21;
	localparam logic [7:0] MIN_QUALITY_RESET = 8'hFF;

	typedef struct packed {
		logic [6:0]        window_len;
		logic signed [7:0] min_quality;
		logic              rna_mode;
		logic              reject_ambiguous;
		logic              homopolymer_merge;
	} cfg_t;

	typedef struct packed {
		logic [7:0] base_char;
		logic [7:0] quality_char;
		logic       has_quality;
		logic       last_base;
	} in_item_t;

	typedef struct packed {
		logic [2:0] base_code;
		logic [6:0] base_quality;
		logic       low_flag;
		logic [6:0] good_run;
		logic [1:0] window_class;
		logic [1:0] error_code;
		logic       last_of_record;
	} out_item_t;

	// One queue entry: either an error result, or one or two finished bases.
	// The second base, when present, always closes the record.
	typedef struct packed {
		logic       is_error;
		logic [1:0] error_code;
		logic [2:0] a_base;
		logic [6:0] a_quality;
		logic       a_last;
		logic       b_valid;
		logic [2:0] b_base;
		logic [6:0] b_quality;
	} cmd_t;

endpackage

// File: design/rbkwq_if.sv
// Valid/ready channel interfaces for the input bases and the qualified results.
// Depends on rbkwq_pkg for the payload types.
interface rbkwq_in_if;
	import rbkwq_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t item;
	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface rbkwq_out_if;
	import rbkwq_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t item;
	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

// File: design/rbkwq_front.sv
// Front end: decodes each base, checks quality, tracks the held base and the
// record error, and pushes result commands into the queue. Depends on rbkwq_pkg.
module rbkwq_front (
	input  logic              clk,
	input  logic              arst_n,
	input  rbkwq_pkg::cfg_t   cfg,
	rbkwq_in_if.sink          bases,
	input  logic              queue_full,
	output logic              push,
	output rbkwq_pkg::cmd_t   push_cmd
);
	import rbkwq_pkg::*;

	logic       held_valid_q;
	logic [2:0] held_base_q;
	logic [6:0] held_quality_q;
	logic [1:0] record_error_q;

	logic       held_valid_n;
	logic [2:0] held_base_n;
	logic [6:0] held_quality_n;
	logic [1:0] record_error_n;

	logic       accept;
	logic [7:0] ch;
	logic [2:0] code;
	logic [7:0] q_sub;
	logic [6:0] q;
	logic [6:0] merged_q;
	logic [1:0] err;
	logic       clear_rec;

	assign bases.ready = !queue_full;
	assign accept = bases.valid && bases.ready;

	always_comb begin
		ch = bases.item.base_char;
		if (ch >= 8'h61 && ch <= 8'h7A) begin
			ch = ch - 8'd32;
		end
		if (cfg.rna_mode && ch == 8'h55) begin
			ch = 8'h54;
		end
		case (ch)
			8'h41: code = BASE_A;
			8'h43: code = BASE_C;
			8'h47: code = BASE_G;
			8'h54: code = BASE_T;
			default: code = BASE_N;
		endcase
	end

	assign q_sub = bases.item.quality_char - PHRED_OFFSET;
	assign q = bases.item.has_quality ? q_sub[6:0] : 7'd0;
	assign merged_q = (bases.item.has_quality && q < held_quality_q) ? q : held_quality_q;

	always_comb begin
		if (!cfg.min_quality[7] && !bases.item.has_quality) begin
			err = ERR_QUAL_MISSING;
		end else if (code == BASE_N && cfg.reject_ambiguous) begin
			err = ERR_AMBIGUOUS;
		end else if (bases.item.has_quality &&
				(bases.item.quality_char < PHRED_OFFSET ||
				bases.item.quality_char > PHRED_TOP)) begin
			err = ERR_QUAL_RANGE;
		end else begin
			err = ERR_NONE;
		end
	end

	always_comb begin
		held_valid_n   = held_valid_q;
		held_base_n    = held_base_q;
		held_quality_n = held_quality_q;
		record_error_n = record_error_q;
		push           = 1'b0;
		push_cmd       = '0;
		clear_rec      = 1'b0;
		if (accept) begin
			clear_rec = bases.item.last_base;
			if (record_error_q != ERR_NONE) begin
				push                = bases.item.last_base;
				push_cmd.is_error   = 1'b1;
				push_cmd.error_code = record_error_q;
			end else if (err != ERR_NONE) begin
				held_valid_n        = 1'b0;
				record_error_n      = err;
				push                = bases.item.last_base;
				push_cmd.is_error   = 1'b1;
				push_cmd.error_code = err;
			end else if (cfg.homopolymer_merge && held_valid_q && held_base_q == code) begin
				held_quality_n     = merged_q;
				push               = bases.item.last_base;
				push_cmd.a_base    = held_base_q;
				push_cmd.a_quality = merged_q;
				push_cmd.a_last    = 1'b1;
			end else begin
				held_valid_n   = 1'b1;
				held_base_n    = code;
				held_quality_n = q;
				if (held_valid_q) begin
					push               = 1'b1;
					push_cmd.a_base    = held_base_q;
					push_cmd.a_quality = held_quality_q;
					push_cmd.b_valid   = bases.item.last_base;
					push_cmd.b_base    = code;
					push_cmd.b_quality = q;
				end else begin
					push               = bases.item.last_base;
					push_cmd.a_base    = code;
					push_cmd.a_quality = q;
					push_cmd.a_last    = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q   <= 1'b0;
			held_base_q    <= BASE_A;
			held_quality_q <= 7'd0;
			record_error_q <= ERR_NONE;
		end else if (clear_rec) begin
			held_valid_q   <= 1'b0;
			held_base_q    <= BASE_A;
			held_quality_q <= 7'd0;
			record_error_q <= ERR_NONE;
		end else begin
			held_valid_q   <= held_valid_n;
			held_base_q    <= held_base_n;
			held_quality_q <= held_quality_n;
			record_error_q <= record_error_n;
		end
	end

`ifndef SYNTHESIS
	// Once a record has failed, nothing may be held back for emission.
	assert property (@(posedge clk) disable iff (!arst_n)
		record_error_q != ERR_NONE |-> !held_valid_q)
		else $error("front: base held while record is in error");
`endif

endmodule

// File: design/rbkwq_cmd_fifo.sv
// Short command queue between the front end and the back end.
// Depends on rbkwq_pkg for the entry type and depth.
module rbkwq_cmd_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rbkwq_pkg::cmd_t push_cmd,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output rbkwq_pkg::cmd_t head_cmd
);
	import rbkwq_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = count_q == CNT_W'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_cmd   = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> !full)
		else $error("cmd_fifo: push into a full queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("cmd_fifo: pop from an empty queue");
`endif

endmodule

// File: design/rbkwq_back.sv
// Back end: expands queue commands into results, keeps the per-record window
// counters and drives the registered result channel. Depends on rbkwq_pkg.
module rbkwq_back #(
	parameter int MAX_KMER = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  rbkwq_pkg::cfg_t cfg,
	input  logic            head_valid,
	input  rbkwq_pkg::cmd_t head_cmd,
	output logic            pop,
	rbkwq_out_if.source     results
);
	import rbkwq_pkg::*;

	localparam logic [6:0] KMAX = 7'(MAX_KMER);

	logic       phase_q;
	logic [6:0] position_q;
	logic [6:0] since_n_q;
	logic [6:0] since_low_q;
	logic [6:0] run_q;
	logic       out_valid_q;
	out_item_t  out_item_q;

	logic       load;
	logic       done;
	logic [6:0] k;
	logic [2:0] cur_base;
	logic [6:0] cur_q;
	logic       cur_last;
	logic       is_n;
	logic       low;
	logic [6:0] position_n;
	logic [6:0] since_n_n;
	logic [6:0] since_low_n;
	logic [6:0] run_n;
	out_item_t  res;

	function automatic logic [6:0] sat_inc(input logic [6:0] v);
		return (v == CNT_MAX) ? CNT_MAX : v + 7'd1;
	endfunction

	assign load = head_valid && (!out_valid_q || results.ready);
	assign done = head_cmd.is_error || phase_q || !head_cmd.b_valid;
	assign pop  = load && done;

	assign k = (cfg.window_len == 7'd0) ? 7'd1 :
		(cfg.window_len > KMAX) ? KMAX : cfg.window_len;

	assign cur_base = phase_q ? head_cmd.b_base : head_cmd.a_base;
	assign cur_q    = phase_q ? head_cmd.b_quality : head_cmd.a_quality;
	assign cur_last = phase_q || head_cmd.a_last;

	assign is_n = cur_base == BASE_N;
	assign low  = !cfg.min_quality[7] && ({1'b0, cur_q} < cfg.min_quality);

	assign position_n  = sat_inc(position_q);
	assign since_n_n   = is_n ? 7'd0 : sat_inc(since_n_q);
	assign since_low_n = low ? 7'd0 : sat_inc(since_low_q);
	assign run_n       = (is_n || low) ? 7'd0 : ((run_q >= k) ? k : run_q + 7'd1);

	always_comb begin
		res = '0;
		if (head_cmd.is_error) begin
			res.error_code     = head_cmd.error_code;
			res.last_of_record = 1'b1;
		end else begin
			res.base_code      = cur_base;
			res.base_quality   = cur_q;
			res.low_flag       = low;
			res.good_run       = (run_n > k) ? k : run_n;
			res.last_of_record = cur_last;
			if (position_n >= k) begin
				if (since_n_n < k) begin
					res.window_class = CLS_AMBIGUOUS;
				end else if (since_low_n < k) begin
					res.window_class = CLS_LOW;
				end else begin
					res.window_class = CLS_ACCEPTED;
				end
			end else begin
				res.window_class = CLS_NONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= 1'b0;
			position_q  <= 7'd0;
			since_n_q   <= CNT_MAX;
			since_low_q <= CNT_MAX;
			run_q       <= 7'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
				phase_q     <= !done;
				if (res.last_of_record) begin
					position_q  <= 7'd0;
					since_n_q   <= CNT_MAX;
					since_low_q <= CNT_MAX;
					run_q       <= 7'd0;
				end else begin
					position_q  <= position_n;
					since_n_q   <= since_n_n;
					since_low_q <= since_low_n;
					run_q       <= run_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_item_q <= res;
		end
	end

	assign results.valid = out_valid_q;
	assign results.item  = out_item_q;

`ifndef SYNTHESIS
	// An error result closes its record and carries no window information.
	assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.item.error_code != ERR_NONE |->
		results.item.last_of_record && results.item.window_class == CLS_NONE)
		else $error("back: malformed error result");
`endif

endmodule

// File: design/read_base_kmer_window_qualifier.sv
// Top level of the read base k-window qualifier: configuration registers and the
// front end, command queue and back end. Depends on rbkwq_pkg and rbkwq_if.
//
// The block accepts one sequence base per cycle on the bases channel and
// delivers qualified bases on the results channel. Each base is decoded
// (uppercased, U mapped to T in RNA mode, anything outside ACGT turned into N
// or rejecting the record), its quality byte is checked against the printable
// Phred+33 range, and, with homopolymer merging on, equal consecutive bases are
// folded into one that keeps the lowest quality. A finished base leaves only
// when the next distinct base arrives or the record ends, so results trail
// their inputs by one base. Each result carries the base code, its quality, a
// low-quality flag, the good-run length saturated at k, and the class of the
// k-window ending at that base. A record that fails gives exactly one error
// result, at its last item, with an error code, last_of_record set and all other
// fields zero, after any bases it emitted before failing; the downstream discards
// that record. The front end takes a new item in every cycle while the four-entry
// command queue has room. The back end turns each command into results through a
// single output register; an item that both finishes the held base and ends the
// record gives two results, sent in turn before its command is popped, and the
// back end otherwise takes one command per cycle while the output is not
// stalled. Results pass through the command queue and the output register.
// Configuration registers are written through cfg_we, cfg_index and cfg_data;
// the user must write them only while the block is idle, which the block does
// not enforce itself, and writes apply from the next base that is emitted.
module read_base_kmer_window_qualifier #(
	parameter int MAX_KMER = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data,
	rbkwq_in_if.sink   bases,
	rbkwq_out_if.source results
);
	import rbkwq_pkg::*;

	// Configuration registers.
	cfg_t cfg_q;

	// Front end to queue, and queue to back end.
	logic push;
	cmd_t push_cmd;
	logic queue_full;
	logic pop;
	logic head_valid;
	cmd_t head_cmd;

	// Register writes. An index beyond the register list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_len        <= WINDOW_LEN_RESET;
			cfg_q.min_quality       <= MIN_QUALITY_RESET;
			cfg_q.rna_mode          <= 1'b0;
			cfg_q.reject_ambiguous  <= 1'b0;
			cfg_q.homopolymer_merge <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WINDOW_LEN:        cfg_q.window_len        <= cfg_data[6:0];
				CFG_MIN_QUALITY:       cfg_q.min_quality       <= cfg_data;
				CFG_RNA_MODE:          cfg_q.rna_mode          <= cfg_data[0];
				CFG_REJECT_AMBIGUOUS:  cfg_q.reject_ambiguous  <= cfg_data[0];
				CFG_HOMOPOLYMER_MERGE: cfg_q.homopolymer_merge <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// The front end classifies every item and decides which results it causes.
	rbkwq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.bases      (bases),
		.queue_full (queue_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	// The queue lets the front keep accepting while the output is stalled.
	rbkwq_cmd_fifo u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// The back end owns the window counters and the registered result.
	rbkwq_back #(
		.MAX_KMER (MAX_KMER)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.results    (results)
	);

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for read_base_kmer_window_qualifier: a scoreboard class predicts
// every qualified base from the accepted input transfers, and plain tasks drive the block.
// Depends on rbkwq_pkg, rbkwq_if and the block's RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rbkwq_pkg::*;

	localparam int MAX_KMER = 64;
	// Watchdog limit on the length of the whole run.
	localparam int CYCLE_LIMIT = 60000;

	// The scoreboard keeps its own copy of the registers and of the per-record state. Each
	// accepted base is run through the same decode, error, merge and window rules as the
	// block, and the results it causes are queued until the block delivers them.
	class qualifier_scoreboard;
		int         kmer;
		int         min_q;
		bit         rna;
		bit         reject;
		bit         merge;
		bit         held_valid;
		logic [2:0] held_base;
		logic [6:0] held_q;
		int         pos_cnt;
		int         since_n;
		int         since_low;
		int         run_len;
		logic [1:0] rec_err;
		out_item_t  due_results[$];
		int         mismatches;

		function new();
			kmer = WINDOW_LEN_RESET;
			min_q = $signed(MIN_QUALITY_RESET);
			rna = 1'b0;
			reject = 1'b0;
			merge = 1'b0;
			mismatches = 0;
			clear_record();
		endfunction

		function void clear_record();
			held_valid = 1'b0;
			held_base = BASE_A;
			held_q = '0;
			pos_cnt = 0;
			since_n = CNT_MAX;
			since_low = CNT_MAX;
			run_len = 0;
			rec_err = ERR_NONE;
		endfunction

		function void set_reg(logic [2:0] idx, logic [7:0] data);
			case (idx)
				CFG_WINDOW_LEN:        kmer = data[6:0];
				CFG_MIN_QUALITY:       min_q = $signed(data);
				CFG_RNA_MODE:          rna = data[0];
				CFG_REJECT_AMBIGUOUS:  reject = data[0];
				CFG_HOMOPOLYMER_MERGE: merge = data[0];
				default:               ;
			endcase
		endfunction

		function int bump(int v);
			return (v >= CNT_MAX) ? CNT_MAX : v + 1;
		endfunction

		// The held base is finished: counters move and one result is queued. The window
		// length is clamped into 1..MAX_KMER, so zero acts as one.
		function void finish_held(bit last);
			int        k;
			bit        is_n;
			bit        low;
			out_item_t r;
			k = (kmer < 1) ? 1 : ((kmer > MAX_KMER) ? MAX_KMER : kmer);
			is_n = (held_base == BASE_N);
			low = (int'(held_q) < min_q);
			pos_cnt = bump(pos_cnt);
			since_n = is_n ? 0 : bump(since_n);
			since_low = low ? 0 : bump(since_low);
			if (is_n || low) begin
				run_len = 0;
			end else begin
				run_len = (run_len >= k) ? k : run_len + 1;
			end
			r = '0;
			r.base_code = held_base;
			r.base_quality = held_q;
			r.low_flag = low;
			r.good_run = 7'((run_len > k) ? k : run_len);
			r.window_class = CLS_NONE;
			if (pos_cnt >= k) begin
				// An N in the window outranks a low-quality base.
				if (since_n < k) begin
					r.window_class = CLS_AMBIGUOUS;
				end else if (since_low < k) begin
					r.window_class = CLS_LOW;
				end else begin
					r.window_class = CLS_ACCEPTED;
				end
			end
			r.last_of_record = last;
			due_results = {due_results, r};
		endfunction

		function void close_with_error(logic [1:0] code);
			out_item_t r;
			r = '0;
			r.error_code = code;
			r.last_of_record = 1'b1;
			due_results = {due_results, r};
			clear_record();
		endfunction

		function void take_base(in_item_t it);
			logic [7:0] ch;
			logic [2:0] code;
			logic [6:0] q;
			logic [1:0] err;
			// A failed record gives nothing until its last item closes it.
			if (rec_err != ERR_NONE) begin
				if (it.last_base) close_with_error(rec_err);
				return;
			end
			ch = it.base_char;
			if (ch >= "a" && ch <= "z") ch = ch - 8'd32;
			if (rna && ch == "U") ch = "T";
			case (ch)
				"A":     code = BASE_A;
				"C":     code = BASE_C;
				"G":     code = BASE_G;
				"T":     code = BASE_T;
				default: code = BASE_N;
			endcase
			err = ERR_NONE;
			if (min_q >= 0 && !it.has_quality) begin
				err = ERR_QUAL_MISSING;
			end else if (code == BASE_N && reject) begin
				err = ERR_AMBIGUOUS;
			end else if (it.has_quality &&
					(it.quality_char < PHRED_OFFSET || it.quality_char > PHRED_TOP)) begin
				err = ERR_QUAL_RANGE;
			end
			if (err != ERR_NONE) begin
				// The held base is dropped along with the rest of the record.
				held_valid = 1'b0;
				rec_err = err;
				if (it.last_base) close_with_error(err);
				return;
			end
			q = it.has_quality ? 7'(it.quality_char - PHRED_OFFSET) : 7'd0;
			if (merge && held_valid && held_base == code) begin
				if (it.has_quality && q < held_q) held_q = q;
				if (it.last_base) begin
					finish_held(1'b1);
					clear_record();
				end
				return;
			end
			if (held_valid) finish_held(1'b0);
			held_valid = 1'b1;
			held_base = code;
			held_q = q;
			if (it.last_base) begin
				finish_held(1'b1);
				clear_record();
			end
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				mismatches++;
				$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (due_results.size() == 0) begin
				mismatches++;
				$display("%0t: expected no result, got %p", $time, got);
				return;
			end
			want = due_results.pop_front();
			compare_field("base_code", want.base_code, got.base_code);
			compare_field("base_quality", want.base_quality, got.base_quality);
			compare_field("low_flag", want.low_flag, got.low_flag);
			compare_field("good_run", want.good_run, got.good_run);
			compare_field("window_class", want.window_class, got.window_class);
			compare_field("error_code", want.error_code, got.error_code);
			compare_field("last_of_record", want.last_of_record, got.last_of_record);
		endfunction

		function int pending();
			return due_results.size();
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [2:0] cfg_index;
	logic [7:0] cfg_data;

	rbkwq_in_if  bases();
	rbkwq_out_if results();

	qualifier_scoreboard sb;

	// While steady is set, neither side idles: the block runs at full rate.
	bit         steady = 1'b0;
	int         cycles = 0;

	// State of the record that the random stimulus is in the middle of.
	int         rec_left = 0;
	bit         rec_hq;
	logic [7:0] prev_char = "A";

	read_base_kmer_window_qualifier #(.MAX_KMER(MAX_KMER)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.bases     (bases),
		.results   (results)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// The result side stalls at random, except during the steady stretch.
	always @(posedge clk) begin
		results.ready <= steady || ($urandom_range(0, 99) >= 36);
	end

	// Both channels are observed at the edge itself, before any of this edge's updates land.
	// A result transfer is checked before an input transfer of the same edge is noted, since
	// no result can come from an input taken at that very edge.
	always @(posedge clk) begin
		if (results.valid === 1'b1 && results.ready === 1'b1) sb.check_result(results.item);
		if (bases.valid === 1'b1 && bases.ready === 1'b1) sb.take_base(bases.item);
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("read_base_kmer_window_qualifier test failed");
			$finish;
		end
	end

	// Random gaps on the input side. While valid is low the payload carries junk, which the
	// block must ignore.
	task automatic idle_input();
		logic [31:0] raw;
		while (!steady && $urandom_range(0, 99) < 36) begin
			raw = $urandom;
			bases.valid <= 1'b0;
			bases.item <= raw[$bits(in_item_t)-1:0];
			@(posedge clk);
		end
	endtask

	// Offers one base and returns at the edge where the transfer happens. Valid stays high on
	// return so that a following base can be offered without a bubble.
	task automatic offer_base(logic [7:0] b, logic [7:0] q, bit hq, bit last);
		in_item_t it;
		idle_input();
		it.base_char = b;
		it.quality_char = q;
		it.has_quality = hq;
		it.last_base = last;
		bases.valid <= 1'b1;
		bases.item <= it;
		do @(posedge clk); while (bases.ready !== 1'b1);
	endtask

	// Lets every expected result come out, then waits further for merged or dropped bases
	// still in the pipeline, so that the block is idle for a register write.
	task automatic settle();
		bases.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (6) @(posedge clk);
	endtask

	// Writes all five registers, one per cycle. Upper data bits that a register does not
	// keep are randomized to show that they are ignored.
	task automatic configure(logic [7:0] k, logic [7:0] minq, bit rna, bit rej, bit merge);
		logic [2:0] idx[5];
		logic [7:0] val[5];
		idx = '{CFG_WINDOW_LEN, CFG_MIN_QUALITY, CFG_RNA_MODE, CFG_REJECT_AMBIGUOUS,
			CFG_HOMOPOLYMER_MERGE};
		val = '{k, minq, {7'($urandom), rna}, {7'($urandom), rej}, {7'($urandom), merge}};
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
			sb.set_reg(idx[i], val[i]);
		end
		cfg_we <= 1'b0;
	endtask

	// Mostly bases from the usual alphabet in both cases, sometimes any byte at all, and often a
	// repeat of the previous base so that homopolymer runs form.
	function automatic logic [7:0] pick_char(logic [7:0] prev, bit cont);
		string alpha = "ACGTacgtUuN";
		if (cont && $urandom_range(0, 99) < 30) return prev;
		if ($urandom_range(0, 99) < 10) return 8'($urandom);
		return alpha[$urandom_range(0, 10)];
	endfunction

	// One base of a random record. Records are mostly short, with some long enough to fill
	// the widest window and to saturate the position counter.
	task automatic next_random_base();
		logic [7:0] b;
		logic [7:0] q;
		int         r;
		bit         cont;
		cont = (rec_left != 0);
		if (!cont) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				rec_left = $urandom_range(1, 12);
			end else if (r < 95) begin
				rec_left = $urandom_range(13, 80);
			end else begin
				rec_left = $urandom_range(81, 200);
			end
			rec_hq = ($urandom_range(0, 9) != 0);
		end
		b = pick_char(prev_char, cont);
		q = ($urandom_range(0, 99) < 2) ? 8'($urandom) : 8'($urandom_range(33, 126));
		offer_base(b, q, rec_hq, rec_left == 1);
		prev_char = b;
		rec_left--;
	endtask

	// The first phases pin the register extremes; the rest draw settings at random.
	task automatic phase_config(int p);
		int         r;
		logic [6:0] k;
		logic [7:0] minq;
		case (p)
			0: configure(8'd127, 8'd93, 1'b0, 1'b0, 1'b0);
			1: configure(8'd64, 8'd94, 1'b1, 1'b1, 1'b1);
			2: configure(8'd65, 8'hFF, 1'b1, 1'b0, 1'b1);
			3: configure(8'd1, 8'd0, 1'b0, 1'b1, 1'b0);
			4: configure(8'd0, 8'd127, 1'b1, 1'b0, 1'b0);
			default: begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					k = 7'($urandom_range(1, 8));
				end else if (r < 85) begin
					k = 7'($urandom_range(9, 64));
				end else if (r < 93) begin
					k = 7'd0;
				end else begin
					k = 7'($urandom_range(65, 127));
				end
				r = $urandom_range(0, 99);
				if (r < 25) begin
					minq = 8'hFF;
				end else if (r < 35) begin
					minq = 8'($urandom_range(128, 255));
				end else if (r < 85) begin
					minq = 8'($urandom_range(0, 60));
				end else begin
					minq = 8'($urandom_range(61, 127));
				end
				configure({1'($urandom), k}, minq, 1'($urandom), 1'($urandom), 1'($urandom));
			end
		endcase
	endtask

	initial begin
		int count;
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_WINDOW_LEN;
		cfg_data = '0;
		bases.valid = 1'b0;
		bases.item = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Window of three, threshold 20, RNA mode on.
		configure(8'd3, 8'd20, 1'b1, 1'b0, 1'b0);
		offer_base("a", 8'd73, 1'b1, 1'b0);   // lowercase is folded to upper case
		offer_base("c", 8'd33, 1'b1, 1'b0);   // lowest printable quality, a low base
		offer_base("G", 8'd126, 1'b1, 1'b0);  // highest printable quality
		offer_base("u", 8'd60, 1'b1, 1'b0);   // U reads as T in RNA mode
		offer_base("x", 8'd70, 1'b1, 1'b0);   // anything else becomes N
		offer_base("T", 8'd70, 1'b1, 1'b1);   // the last base flushes two results
		offer_base("g", 8'd50, 1'b1, 1'b1);   // a record of one base
		// Quality byte below the printable range mid-record, then the record runs on.
		offer_base("A", 8'd32, 1'b1, 1'b0);
		offer_base("C", 8'd50, 1'b1, 1'b0);
		offer_base("G", 8'd50, 1'b1, 1'b1);
		offer_base("A", 8'd127, 1'b1, 1'b1);  // above the range on the final base
		// Quality missing while a threshold is set.
		offer_base("A", 8'd0, 1'b0, 1'b0);
		offer_base("C", 8'd255, 1'b0, 1'b1);
		// Registers change in the middle of a record and apply from the next emitted base.
		offer_base("A", 8'd60, 1'b1, 1'b0);
		offer_base("C", 8'd60, 1'b1, 1'b0);
		settle();
		configure(8'd0, 8'h80, 1'b0, 1'b1, 1'b1);
		offer_base("C", 8'd40, 1'b1, 1'b0);   // merges into the held C, keeps the lower quality
		offer_base("a", 8'd40, 1'b1, 1'b0);
		offer_base("A", 8'd35, 1'b1, 1'b0);
		offer_base("U", 8'd40, 1'b1, 1'b1);   // RNA mode off, so U is rejected as ambiguous
		offer_base("G", 8'd0, 1'b0, 1'b0);    // no quality is fine with the threshold off
		offer_base("G", 8'd0, 1'b0, 1'b1);    // a merged final base closes the record
		offer_base("N", 8'd40, 1'b1, 1'b1);   // rejected ambiguous base on the final item

		// Random part: ten phases, each with its own register setting. Records run across
		// phase borders, so some settings change mid-record. Phase four runs with no gaps.
		for (int p = 0; p < 10; p++) begin
			settle();
			phase_config(p);
			steady = (p == 4);
			count = 0;
			while (count < 95) begin
				next_random_base();
				count++;
			end
		end
		settle();

		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("read_base_kmer_window_qualifier test passed");
		end else begin
			$display("read_base_kmer_window_qualifier test failed");
		end
		$finish;
	end
endmodule
